### design/bond_repulsion_energy_accumulator_macros.svh
// Assertion macros for the accumulator, which checks itself.
`ifndef BOND_REPULSION_ENERGY_ACCUMULATOR_MACROS_SVH
`define BOND_REPULSION_ENERGY_ACCUMULATOR_MACROS_SVH

// Checks that a condition implies another in the same cycle.
`define BREA_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks that a condition implies another in the following cycle.
`define BREA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/brea_pkg.sv
package brea_pkg;

  localparam int MAX_ATOMS_DEF = 256;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_BOND = 2'd1;
  localparam logic [1:0] OP_REPULSE = 2'd2;

  localparam logic REG_SPRING = 1'b0;
  localparam logic REG_REPULSION = 1'b1;

  localparam logic [17:0] SPRING_RESET = 18'd128000;
  localparam logic [15:0] REPULSION_RESET = 16'd2560;

  localparam logic [47:0] E_MAX = 48'hFFFF_FFFF_FFFF;

  localparam logic [5:0] SQRT_STEPS = 6'd25;
  localparam logic [5:0] DIV_STEPS = 6'd56;

  typedef struct packed {
    logic start;
    logic is_sqrt;
  } iter_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iter_stat_t;

endpackage

### design/brea_pos_mem.sv
module brea_pos_mem #(
  parameter int DEPTH = brea_pkg::MAX_ATOMS_DEF,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [71:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [71:0]   rdata
);

  logic [71:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/brea_iter.sv
module brea_iter (
  input  logic                 clk,
  input  logic                 rst,
  input  brea_pkg::iter_ctl_t  ctl,
  input  logic [55:0]          operand,
  input  logic [49:0]          divisor,
  output brea_pkg::iter_stat_t stat,
  output logic [55:0]          result
);

  logic [55:0] src;
  logic [50:0] rem;
  logic [49:0] div_r;
  logic [5:0]  cnt;
  logic        sq;
  logic        busy;
  logic        done;
  logic [50:0] rem_sh;
  logic [50:0] trial;
  logic        ge;

  always_comb begin
    if (sq) begin
      rem_sh = {rem[48:0], src[55:54]};
      trial = 51'({result[24:0], 2'b01});
    end else begin
      rem_sh = {rem[49:0], src[55]};
      trial = 51'(div_r);
    end
    ge = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt <= ctl.is_sqrt ? brea_pkg::SQRT_STEPS : brea_pkg::DIV_STEPS;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      src <= operand;
      div_r <= divisor;
      sq <= ctl.is_sqrt;
      rem <= '0;
      result <= '0;
    end else if (busy) begin
      src <= sq ? {src[53:0], 2'b00} : {src[54:0], 1'b0};
      rem <= ge ? rem_sh - trial : rem_sh;
      result <= {result[54:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

### design/bond_repulsion_energy_accumulator.sv
// Takes one word at a time while busy is low. A position load, or a word that adds no term,
// goes straight to the finishing state. A bond or repulsive term reads both positions and
// sums the squared distances, then runs the shared shift-and-subtract unit: 25 steps for the
// square root of a bond term, 56 for the division of a repulsive term, one step per cycle. A
// repulsive term skips the unit when the two atoms coincide. A word with last_term set
// gives one result with done high for exactly one cycle, which the receiver must take then.
`include "bond_repulsion_energy_accumulator_macros.svh"

module bond_repulsion_energy_accumulator #(
  parameter int MAX_ATOMS = brea_pkg::MAX_ATOMS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [17:0]        cfg_data,
  input  logic [1:0]         opcode,
  input  logic [7:0]         first_atom,
  input  logic [7:0]         second_atom,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic signed [23:0] pos_z,
  input  logic [17:0]        rest_length,
  input  logic               last_term,
  output logic               done,
  output logic [47:0]        total_energy,
  output logic               overflow
);

  localparam int AW = $clog2(MAX_ATOMS);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDA = 4'd1;
  localparam logic [3:0] S_RDB = 4'd2;
  localparam logic [3:0] S_SQ0 = 4'd3;
  localparam logic [3:0] S_SQ1 = 4'd4;
  localparam logic [3:0] S_SQ2 = 4'd5;
  localparam logic [3:0] S_SQ3 = 4'd6;
  localparam logic [3:0] S_ITER = 4'd7;
  localparam logic [3:0] S_BD = 4'd8;
  localparam logic [3:0] S_H0 = 4'd9;
  localparam logic [3:0] S_H1 = 4'd10;
  localparam logic [3:0] S_H2 = 4'd11;
  localparam logic [3:0] S_ADD = 4'd12;
  localparam logic [3:0] S_FIN = 4'd13;

  logic [3:0]  state;
  logic [1:0]  op_r;
  logic [7:0]  a_r;
  logic [7:0]  b_r;
  logic [17:0] rest_r;
  logic        last_r;
  logic [17:0] hk;
  logic [15:0] coef;
  logic [71:0] pa;
  logic [49:0] r2;
  logic [49:0] prod;
  logic [49:0] d2;
  logic [67:0] acc;
  logic [55:0] term;
  logic [47:0] sum;
  logic        flag;

  logic        accept;
  logic        a_ok;
  logic        b_ok;
  logic        mem_we;
  logic        mem_re;
  logic [AW-1:0] mem_raddr;
  logic [71:0] rdata;
  logic [24:0] diff_x;
  logic [24:0] diff_y;
  logic [24:0] diff_z;
  logic [24:0] abs_x;
  logic [24:0] abs_y;
  logic [24:0] abs_z;
  logic [24:0] mul_a;
  logic [24:0] mul_b;
  logic [49:0] mul_p;
  logic [49:0] r2_full;
  logic [24:0] root;
  logic [24:0] bond_dev;
  logic [56:0] tsum;

  brea_pkg::iter_ctl_t  iter_ctl;
  brea_pkg::iter_stat_t iter_st;
  logic [55:0] iter_op;
  logic [55:0] iter_res;

  assign accept = start && !busy;
  assign a_ok = 32'(first_atom) < MAX_ATOMS;
  assign b_ok = 32'(second_atom) < MAX_ATOMS;
  assign mem_we = accept && (opcode == brea_pkg::OP_LOAD) && a_ok;
  assign mem_re = (state == S_RDA) || (state == S_RDB);
  assign mem_raddr = (state == S_RDA) ? AW'(a_r) : AW'(b_r);

  brea_pos_mem #(
    .DEPTH(MAX_ATOMS),
    .AW(AW)
  ) u_mem (
    .clk(clk),
    .we(mem_we),
    .waddr(AW'(first_atom)),
    .wdata({pos_x, pos_y, pos_z}),
    .re(mem_re),
    .raddr(mem_raddr),
    .rdata(rdata)
  );

  assign diff_x = {pa[71], pa[71:48]} - {rdata[71], rdata[71:48]};
  assign diff_y = {pa[47], pa[47:24]} - {rdata[47], rdata[47:24]};
  assign diff_z = {pa[23], pa[23:0]} - {rdata[23], rdata[23:0]};
  assign abs_x = diff_x[24] ? -diff_x : diff_x;
  assign abs_y = diff_y[24] ? -diff_y : diff_y;
  assign abs_z = diff_z[24] ? -diff_z : diff_z;

  assign root = iter_res[24:0];
  assign bond_dev = (root >= 25'(rest_r)) ? root - 25'(rest_r) : 25'(rest_r) - root;

  always_comb begin
    unique case (state)
      S_SQ0: begin
        mul_a = abs_x;
        mul_b = abs_x;
      end
      S_SQ1: begin
        mul_a = abs_y;
        mul_b = abs_y;
      end
      S_SQ2: begin
        mul_a = abs_z;
        mul_b = abs_z;
      end
      S_BD: begin
        mul_a = bond_dev;
        mul_b = bond_dev;
      end
      S_H0: begin
        mul_a = 25'(hk);
        mul_b = prod[24:0];
      end
      default: begin
        mul_a = 25'(hk);
        mul_b = d2[49:25];
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign r2_full = r2 + prod;
  assign tsum = 57'(sum) + 57'(term);

  assign iter_ctl.start = (state == S_SQ3) &&
                          ((op_r == brea_pkg::OP_BOND) || (r2_full != '0));
  assign iter_ctl.is_sqrt = (op_r == brea_pkg::OP_BOND);
  assign iter_op = iter_ctl.is_sqrt ? {r2_full, 6'b0} : {coef, 40'b0};

  brea_iter u_iter (
    .clk(clk),
    .rst(rst),
    .ctl(iter_ctl),
    .operand(iter_op),
    .divisor(r2_full),
    .stat(iter_st),
    .result(iter_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      hk <= brea_pkg::SPRING_RESET;
      coef <= brea_pkg::REPULSION_RESET;
      sum <= '0;
      flag <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        if (cfg_index == brea_pkg::REG_SPRING) begin
          hk <= cfg_data;
        end else begin
          coef <= cfg_data[15:0];
        end
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (((opcode == brea_pkg::OP_BOND) || (opcode == brea_pkg::OP_REPULSE)) &&
                a_ok && b_ok) begin
              state <= S_RDA;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_RDA: state <= S_RDB;
        S_RDB: state <= S_SQ0;
        S_SQ0: state <= S_SQ1;
        S_SQ1: state <= S_SQ2;
        S_SQ2: state <= S_SQ3;
        S_SQ3: begin
          if (iter_ctl.start) begin
            state <= S_ITER;
          end else begin
            sum <= brea_pkg::E_MAX;
            flag <= 1'b1;
            state <= S_FIN;
          end
        end
        S_ITER: begin
          if (iter_st.done) begin
            state <= (op_r == brea_pkg::OP_BOND) ? S_BD : S_ADD;
          end
        end
        S_BD: state <= S_H0;
        S_H0: state <= S_H1;
        S_H1: state <= S_H2;
        S_H2: state <= S_ADD;
        S_ADD: begin
          if ((term > 56'(brea_pkg::E_MAX)) || (tsum > 57'(brea_pkg::E_MAX))) begin
            sum <= brea_pkg::E_MAX;
            flag <= 1'b1;
          end else begin
            sum <= tsum[47:0];
          end
          state <= S_FIN;
        end
        S_FIN: begin
          done <= last_r;
          if (last_r) begin
            sum <= '0;
            flag <= 1'b0;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= opcode;
      a_r <= first_atom;
      b_r <= second_atom;
      rest_r <= rest_length;
      last_r <= last_term;
    end
    if (state == S_RDB) begin
      pa <= rdata;
      r2 <= '0;
    end
    if ((state == S_SQ1) || (state == S_SQ2) || (state == S_SQ3)) begin
      r2 <= r2_full;
    end
    if ((state == S_SQ0) || (state == S_SQ1) || (state == S_SQ2) ||
        (state == S_BD) || (state == S_H0) || (state == S_H1)) begin
      prod <= mul_p;
    end
    if (state == S_H0) begin
      d2 <= prod;
    end
    if (state == S_H1) begin
      acc <= 68'(prod);
    end
    if (state == S_H2) begin
      term <= 56'((acc + (68'(prod) << 25)) >> 24);
    end
    if ((state == S_ITER) && iter_st.done && (op_r != brea_pkg::OP_BOND)) begin
      term <= iter_res;
    end
    if ((state == S_FIN) && last_r) begin
      total_energy <= sum;
      overflow <= flag;
    end
  end

  assign busy = (state != S_IDLE);

  `BREA_ASSERT(a_done_after_work, done, $past(busy), "result without a finished word")
  `BREA_ASSERT(a_ovf_max, done && overflow, total_energy == brea_pkg::E_MAX, "flag without max")
  `BREA_ASSERT(a_iter_free, iter_ctl.start, !iter_st.busy, "shared unit restarted while busy")
  `BREA_ASSERT_NEXT(a_iter_runs, iter_ctl.start, iter_st.busy, "shared unit did not start")

endmodule
